### rtl/bnc_pkg.sv
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types and constants of the bracket nesting checker.
// ----------------------------------------------------------------------------
package bnc_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int LINE_BITS   = 16;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
  localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

  localparam int RSQ_DEPTH = 4;
  localparam int RSQ_AW    = $clog2(RSQ_DEPTH);
  localparam int RSQ_CW    = $clog2(RSQ_DEPTH + 1);

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_DQUOTE  = 8'd34;
  localparam logic [7:0] CH_SQUOTE  = 8'd39;
  localparam logic [7:0] CH_LPAREN  = 8'd40;
  localparam logic [7:0] CH_RPAREN  = 8'd41;
  localparam logic [7:0] CH_STAR    = 8'd42;
  localparam logic [7:0] CH_SLASH   = 8'd47;
  localparam logic [7:0] CH_LBRACE  = 8'd123;
  localparam logic [7:0] CH_RBRACE  = 8'd125;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [1:0] BR_LROUND = 2'd0;
  localparam logic [1:0] BR_RROUND = 2'd1;
  localparam logic [1:0] BR_LCURLY = 2'd2;
  localparam logic [1:0] BR_RCURLY = 2'd3;

  localparam logic [1:0] VERDICT_BALANCED  = 2'd0;
  localparam logic [1:0] VERDICT_UNMATCHED = 2'd1;
  localparam logic [1:0] VERDICT_OVERFLOW  = 2'd2;

  localparam logic STK_ROUND = 1'b0;
  localparam logic STK_CURLY = 1'b1;

  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'b0001,
    MODE_SQUOTE  = 4'b0010,
    MODE_DQUOTE  = 4'b0100,
    MODE_COMMENT = 4'b1000
  } scan_mode_t;

  typedef enum logic [2:0] {
    OP_OPEN_ROUND  = 3'd0,
    OP_CLOSE_ROUND = 3'd1,
    OP_OPEN_CURLY  = 3'd2,
    OP_CLOSE_CURLY = 3'd3,
    OP_END         = 3'd4
  } op_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic                 kind;
    logic [1:0]           bracket;
    logic [1:0]           verdict;
    logic [LINE_BITS-1:0] line_number;
    logic                 last;
  } out_word_t;

  typedef struct packed {
    op_t                  op;
    logic [LINE_BITS-1:0] line;
  } op_word_t;

  typedef struct packed {
    logic                 kind;
    logic [LINE_BITS-1:0] line;
  } stk_entry_t;

endpackage

### rtl/bnc_front.sv
// ----------------------------------------------------------------------------
// bnc_front
// Character scanner: tracks lines, quotes and comments, turns brackets and
// end of input into operations and queues them for the stack engine.
// ----------------------------------------------------------------------------
module bnc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bnc_pkg::in_word_t  in_word,
  output logic               op_valid,
  output bnc_pkg::op_word_t  op_word,
  input  logic               op_take
);

  logic [bnc_pkg::LINE_BITS-1:0] line_r, line_nxt;
  bnc_pkg::scan_mode_t           mode_r, mode_nxt;
  logic                          slash_r, slash_nxt;

  bnc_pkg::op_word_t             q_r [bnc_pkg::OPQ_DEPTH];
  logic [bnc_pkg::OPQ_AW-1:0]    wp_r, rp_r;
  logic [bnc_pkg::OPQ_CW-1:0]    cnt_r, cnt_nxt;

  logic                          acc;
  logic                          emit;
  bnc_pkg::op_t                  op_code;
  logic [7:0]                    c;
  logic                          rd;

  assign full     = (cnt_r == bnc_pkg::OPQ_CW'(bnc_pkg::OPQ_DEPTH));
  assign acc      = push && !full;
  assign c        = in_word.char_code;
  assign op_valid = (cnt_r != '0);
  assign op_word  = q_r[rp_r];
  assign rd       = op_take && op_valid;

  always_comb begin
    line_nxt  = line_r;
    mode_nxt  = mode_r;
    slash_nxt = slash_r;
    emit      = 1'b0;
    op_code   = bnc_pkg::OP_END;
    if (acc) begin
      if (in_word.cmd == bnc_pkg::CMD_END) begin
        emit = 1'b1;
      end else if (c == bnc_pkg::CH_NEWLINE) begin
        if (line_r != '1) line_nxt = line_r + 1'b1;
        mode_nxt  = bnc_pkg::MODE_NORMAL;
        slash_nxt = 1'b0;
      end else if (mode_r != bnc_pkg::MODE_COMMENT) begin
        if (slash_r && (c == bnc_pkg::CH_SLASH || c == bnc_pkg::CH_STAR)) begin
          mode_nxt  = bnc_pkg::MODE_COMMENT;
          slash_nxt = 1'b0;
        end else begin
          slash_nxt = (c == bnc_pkg::CH_SLASH);
          unique case (mode_r)
            bnc_pkg::MODE_SQUOTE: begin
              if (c == bnc_pkg::CH_SQUOTE) mode_nxt = bnc_pkg::MODE_NORMAL;
            end
            bnc_pkg::MODE_DQUOTE: begin
              if (c == bnc_pkg::CH_DQUOTE) mode_nxt = bnc_pkg::MODE_NORMAL;
            end
            default: begin
              priority if (c == bnc_pkg::CH_SQUOTE) begin
                mode_nxt = bnc_pkg::MODE_SQUOTE;
              end else if (c == bnc_pkg::CH_DQUOTE) begin
                mode_nxt = bnc_pkg::MODE_DQUOTE;
              end else if (c == bnc_pkg::CH_LPAREN) begin
                emit    = 1'b1;
                op_code = bnc_pkg::OP_OPEN_ROUND;
              end else if (c == bnc_pkg::CH_RPAREN) begin
                emit    = 1'b1;
                op_code = bnc_pkg::OP_CLOSE_ROUND;
              end else if (c == bnc_pkg::CH_LBRACE) begin
                emit    = 1'b1;
                op_code = bnc_pkg::OP_OPEN_CURLY;
              end else if (c == bnc_pkg::CH_RBRACE) begin
                emit    = 1'b1;
                op_code = bnc_pkg::OP_CLOSE_CURLY;
              end else begin
                emit = 1'b0;
              end
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (emit && !rd) cnt_nxt = cnt_r + 1'b1;
    else if (!emit && rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= bnc_pkg::LINE_BITS'(1);
      mode_r  <= bnc_pkg::MODE_NORMAL;
      slash_r <= 1'b0;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
    end else begin
      line_r  <= line_nxt;
      mode_r  <= mode_nxt;
      slash_r <= slash_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) wp_r <= wp_r + 1'b1;
      if (rd)   rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      q_r[wp_r].op   <= op_code;
      q_r[wp_r].line <= line_r;
    end
  end

endmodule

### rtl/bnc_back.sv
// ----------------------------------------------------------------------------
// bnc_back
// Stack engine: applies bracket operations to the open-bracket stack,
// builds record and verdict words and queues them for the consumer.
// ----------------------------------------------------------------------------
module bnc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  bnc_pkg::op_word_t  op_word,
  output logic               op_take,
  output logic               empty,
  output bnc_pkg::out_word_t out_word,
  input  logic               pop
);

  // stack: top entry in registers, entry below it prefetched from memory
  bnc_pkg::stk_entry_t          mem [bnc_pkg::STACK_DEPTH];
  bnc_pkg::stk_entry_t          top_r, below_r;
  logic [bnc_pkg::STK_CW-1:0]   stk_cnt_r, stk_cnt_nxt;
  logic [bnc_pkg::STK_AW-1:0]   rd_addr;
  logic                         do_push, do_pop;
  logic                         push_kind;

  logic                         stop_r, stop_nxt;
  logic                         pend_r, pend_nxt;
  bnc_pkg::out_word_t           pend_word_r, vd;

  bnc_pkg::out_word_t           rq_r [bnc_pkg::RSQ_DEPTH];
  logic [bnc_pkg::RSQ_AW-1:0]   wp_r, rp_r;
  logic [bnc_pkg::RSQ_CW-1:0]   rq_cnt_r, rq_cnt_nxt;
  logic                         room, wr_en, rd;
  bnc_pkg::out_word_t           wr_word;

  logic                         work, has_top, stk_full, top_round, top_curly, vd_hit;
  logic [bnc_pkg::STK_CW-1:0]   stk_cnt_m2;

  assign room      = (rq_cnt_r != bnc_pkg::RSQ_CW'(bnc_pkg::RSQ_DEPTH));
  assign op_take   = op_valid && (stop_r || room);
  assign work      = op_take && !stop_r;
  assign empty     = (rq_cnt_r == '0);
  assign out_word  = rq_r[rp_r];
  assign rd        = pop && !empty;

  assign has_top   = (stk_cnt_r != '0);
  assign stk_full  = (stk_cnt_r == bnc_pkg::STK_CW'(bnc_pkg::STACK_DEPTH));
  assign top_round = has_top && (top_r.kind == bnc_pkg::STK_ROUND);
  assign top_curly = has_top && (top_r.kind == bnc_pkg::STK_CURLY);

  always_comb begin
    do_push   = 1'b0;
    do_pop    = 1'b0;
    push_kind = bnc_pkg::STK_ROUND;
    vd_hit    = 1'b0;
    vd.kind        = bnc_pkg::KIND_VERDICT;
    vd.bracket     = op_word.op[1:0];
    vd.verdict     = bnc_pkg::VERDICT_UNMATCHED;
    vd.line_number = op_word.line;
    vd.last        = 1'b1;
    unique case (op_word.op)
      bnc_pkg::OP_OPEN_ROUND: begin
        if (stk_full) begin
          vd_hit     = 1'b1;
          vd.verdict = bnc_pkg::VERDICT_OVERFLOW;
        end else begin
          do_push = 1'b1;
        end
      end
      bnc_pkg::OP_CLOSE_ROUND: begin
        if (top_round) do_pop = 1'b1;
        else vd_hit = 1'b1;
      end
      bnc_pkg::OP_OPEN_CURLY: begin
        priority if (top_round) begin
          vd_hit         = 1'b1;
          vd.bracket     = bnc_pkg::BR_LROUND;
          vd.line_number = top_r.line;
        end else if (stk_full) begin
          vd_hit     = 1'b1;
          vd.verdict = bnc_pkg::VERDICT_OVERFLOW;
        end else begin
          do_push   = 1'b1;
          push_kind = bnc_pkg::STK_CURLY;
        end
      end
      bnc_pkg::OP_CLOSE_CURLY: begin
        if (top_curly) do_pop = 1'b1;
        else vd_hit = 1'b1;
      end
      default: begin
        vd_hit = 1'b1;
        if (!has_top) begin
          vd.bracket = bnc_pkg::BR_LROUND;
          vd.verdict = bnc_pkg::VERDICT_BALANCED;
        end else begin
          vd.bracket     = (top_r.kind == bnc_pkg::STK_CURLY) ? bnc_pkg::BR_LCURLY
                                                              : bnc_pkg::BR_LROUND;
          vd.line_number = top_r.line;
        end
      end
    endcase
    do_push = do_push && work;
    do_pop  = do_pop && work;
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_word  = pend_word_r;
    pend_nxt = pend_r;
    stop_nxt = stop_r;
    if (pend_r && room) begin
      wr_en    = 1'b1;
      pend_nxt = 1'b0;
    end else if (work) begin
      wr_en = 1'b1;
      if (op_word.op == bnc_pkg::OP_END) begin
        wr_word  = vd;
        stop_nxt = 1'b1;
      end else begin
        wr_word.kind        = bnc_pkg::KIND_RECORD;
        wr_word.bracket     = op_word.op[1:0];
        wr_word.verdict     = bnc_pkg::VERDICT_BALANCED;
        wr_word.line_number = op_word.line;
        wr_word.last        = !vd_hit;
        if (vd_hit) begin
          pend_nxt = 1'b1;
          stop_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    stk_cnt_nxt = stk_cnt_r;
    if (do_push) stk_cnt_nxt = stk_cnt_r + 1'b1;
    else if (do_pop) stk_cnt_nxt = stk_cnt_r - 1'b1;
    stk_cnt_m2 = stk_cnt_nxt - bnc_pkg::STK_CW'(2);
    rd_addr    = stk_cnt_m2[bnc_pkg::STK_AW-1:0];
  end

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (wr_en && !rd) rq_cnt_nxt = rq_cnt_r + 1'b1;
    else if (!wr_en && rd) rq_cnt_nxt = rq_cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_cnt_r <= '0;
      stop_r    <= 1'b0;
      pend_r    <= 1'b0;
      wp_r      <= '0;
      rp_r      <= '0;
      rq_cnt_r  <= '0;
    end else begin
      stk_cnt_r <= stk_cnt_nxt;
      stop_r    <= stop_nxt;
      pend_r    <= pend_nxt;
      rq_cnt_r  <= rq_cnt_nxt;
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd)    rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[stk_cnt_r[bnc_pkg::STK_AW-1:0]] <= '{kind: push_kind, line: op_word.line};
    end
    below_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      top_r.kind <= push_kind;
      top_r.line <= op_word.line;
    end else if (do_pop) begin
      top_r <= below_r;
    end
    if (work && vd_hit) pend_word_r <= vd;
    if (wr_en) rq_r[wp_r] <= wr_word;
  end

endmodule

### rtl/bracket_nesting_checker.sv
// ----------------------------------------------------------------------------
// bracket_nesting_checker
// Checks nesting of round and curly brackets in a stream of text bytes.
// ----------------------------------------------------------------------------
// Takes one word per clock while not full and returns one word per clock
// while not empty. A scanner tracks line numbers, quotes and comments and
// queues each bracket or end of input as an operation; a stack engine
// applies it to a 1024-entry bracket stack, with the top entry held in
// registers and the entry below it prefetched from the stack memory, so
// pushes and pops can run back to back. A result is registered in the
// scanner's operation queue, then in the engine's result queue, before it
// can be popped. A bracket that ends checking gives its record and then its
// verdict once the result queue has room; after a verdict, words are still taken but give no result.
// ----------------------------------------------------------------------------
module bracket_nesting_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bnc_pkg::in_word_t  in_word,
  output logic               empty,
  output bnc_pkg::out_word_t out_word,
  input  logic               pop
);

  logic              op_valid;
  logic              op_take;
  bnc_pkg::op_word_t op_word;

  bnc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .op_valid (op_valid),
    .op_word  (op_word),
    .op_take  (op_take)
  );

  bnc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op_word  (op_word),
    .op_take  (op_take),
    .empty    (empty),
    .out_word (out_word),
    .pop      (pop)
  );

endmodule

### rtl/bnc_checker.sv
// ----------------------------------------------------------------------------
// bnc_checker
// Port-level checks of the bracket nesting checker, bound to the top level.
// ----------------------------------------------------------------------------
module bnc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input bnc_pkg::out_word_t out_word
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("waiting word changed");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.kind == bnc_pkg::KIND_VERDICT) |->
      (out_word.last && out_word.verdict != 2'd3))
    else $error("bad verdict word");

  a_record_code: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.kind == bnc_pkg::KIND_RECORD) |->
      (out_word.verdict == bnc_pkg::VERDICT_BALANCED && out_word.line_number != '0))
    else $error("bad record word");

  a_verdict_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && out_word.kind == bnc_pkg::KIND_RECORD && !out_word.last) |=>
      (empty || out_word.kind == bnc_pkg::KIND_VERDICT))
    else $error("record not followed by verdict");

endmodule

bind bracket_nesting_checker bnc_checker u_bnc_checker (.*);

### test/bracket_nesting_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bracket_nesting_checker_tb
// Self-checking testbench for the bracket nesting checker.
// ----------------------------------------------------------------------------
// Text is generated up front against a shadow copy of the nesting state. Most
// of it is bracket soup that keeps the checker alive, with quotes, comments
// and raw bytes mixed in. The run ends in one randomly chosen verdict,
// followed by words that must be ignored. The sender works in bursts. The
// receiver stalls on a rotating pattern. Every accepted word is run through a
// local nesting predictor, and its result words are checked in order.
// ----------------------------------------------------------------------------
module bracket_nesting_checker_tb;
  import bnc_pkg::*;

  localparam int M_CHECK = 0;
  localparam int M_PLAN  = 1;
  localparam int M_TRY   = 2;

  localparam int         DRAIN_AT    = 700;
  localparam int         TAIL_CYCLES = 20;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_LETTER   = 8'd97;

  typedef enum int {
    FIN_BALANCED,
    FIN_OPEN,
    FIN_BAD_ROUND,
    FIN_BAD_CURLY,
    FIN_CURLY_IN_ROUND,
    FIN_OVERFLOW,
    FIN_EMPTY_CLOSE
  } finale_t;

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  logic      push  = 1'b0;
  logic      full;
  in_word_t  in_word = '0;
  logic      empty;
  out_word_t out_word;
  logic      pop = 1'b0;

  // nesting state: checker copy, generator copy, and a scratch copy
  logic                 brk_kind   [3][STACK_DEPTH];
  logic [LINE_BITS-1:0] brk_line   [3][STACK_DEPTH];
  int                   nest_depth [3];
  logic [LINE_BITS-1:0] cur_line   [3];
  scan_mode_t           scan_st    [3];
  logic                 after_slash[3];
  logic                 halted     [3];
  out_word_t            step_out   [3][2];

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        words_sent = 0;
  int        mismatches = 0;
  int        burst_left = 0;
  int        gap_left   = 0;
  logic [31:0] stall_pat   = '1;
  logic [4:0]  stall_phase = '0;

  bracket_nesting_checker u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .empty   (empty),
    .out_word(out_word),
    .pop     (pop)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic out_word_t mk_word(logic kind, logic [1:0] br, logic [1:0] vd,
                                        logic [LINE_BITS-1:0] ln);
    out_word_t w;
    w.kind        = kind;
    w.bracket     = br;
    w.verdict     = vd;
    w.line_number = ln;
    w.last        = 1'b0;
    return w;
  endfunction

  // Applies one word to state copy m; result words land in step_out[m].
  function automatic int nest_step(int m, in_word_t w);
    int         n;
    int         d;
    logic [7:0] c;
    logic [1:0] br;
    logic       top_round;
    logic       top_curly;
    n = 0;
    d = nest_depth[m];
    c = w.char_code;
    if (halted[m]) return 0;
    if (w.cmd == CMD_END) begin
      if (d == 0)
        step_out[m][0] = mk_word(KIND_VERDICT, BR_LROUND, VERDICT_BALANCED, cur_line[m]);
      else
        step_out[m][0] = mk_word(KIND_VERDICT,
                                 (brk_kind[m][d-1] == STK_CURLY) ? BR_LCURLY : BR_LROUND,
                                 VERDICT_UNMATCHED, brk_line[m][d-1]);
      step_out[m][0].last = 1'b1;
      halted[m] = 1'b1;
      return 1;
    end
    if (c == CH_NEWLINE) begin
      if (cur_line[m] != {LINE_BITS{1'b1}}) cur_line[m] = cur_line[m] + 1'b1;
      scan_st[m]     = MODE_NORMAL;
      after_slash[m] = 1'b0;
      return 0;
    end
    if (scan_st[m] == MODE_COMMENT) return 0;
    if (after_slash[m] && (c == CH_SLASH || c == CH_STAR)) begin
      scan_st[m]     = MODE_COMMENT;
      after_slash[m] = 1'b0;
      return 0;
    end
    after_slash[m] = (c == CH_SLASH);
    if (scan_st[m] == MODE_SQUOTE) begin
      if (c == CH_SQUOTE) scan_st[m] = MODE_NORMAL;
      return 0;
    end
    if (scan_st[m] == MODE_DQUOTE) begin
      if (c == CH_DQUOTE) scan_st[m] = MODE_NORMAL;
      return 0;
    end
    if (c == CH_SQUOTE) begin
      scan_st[m] = MODE_SQUOTE;
      return 0;
    end
    if (c == CH_DQUOTE) begin
      scan_st[m] = MODE_DQUOTE;
      return 0;
    end
    case (c)
      CH_LPAREN: br = BR_LROUND;
      CH_RPAREN: br = BR_RROUND;
      CH_LBRACE: br = BR_LCURLY;
      CH_RBRACE: br = BR_RCURLY;
      default:   return 0;
    endcase
    step_out[m][0] = mk_word(KIND_RECORD, br, VERDICT_BALANCED, cur_line[m]);
    n = 1;
    top_round = (d > 0) && (brk_kind[m][d-1] == STK_ROUND);
    top_curly = (d > 0) && (brk_kind[m][d-1] == STK_CURLY);
    case (br)
      BR_LROUND, BR_LCURLY: begin
        if (br == BR_LCURLY && top_round) begin
          step_out[m][1] = mk_word(KIND_VERDICT, BR_LROUND, VERDICT_UNMATCHED,
                                   brk_line[m][d-1]);
          n = 2;
        end else if (d == STACK_DEPTH) begin
          step_out[m][1] = mk_word(KIND_VERDICT, br, VERDICT_OVERFLOW, cur_line[m]);
          n = 2;
        end else begin
          brk_kind[m][d] = (br == BR_LCURLY) ? STK_CURLY : STK_ROUND;
          brk_line[m][d] = cur_line[m];
          nest_depth[m]  = d + 1;
        end
      end
      BR_RROUND: begin
        if (top_round) nest_depth[m] = d - 1;
        else begin
          step_out[m][1] = mk_word(KIND_VERDICT, br, VERDICT_UNMATCHED, cur_line[m]);
          n = 2;
        end
      end
      default: begin
        if (top_curly) nest_depth[m] = d - 1;
        else begin
          step_out[m][1] = mk_word(KIND_VERDICT, br, VERDICT_UNMATCHED, cur_line[m]);
          n = 2;
        end
      end
    endcase
    if (n == 2) halted[m] = 1'b1;
    step_out[m][n-1].last = 1'b1;
    return n;
  endfunction

  // True if character c would end checking from the generator's current state.
  function automatic bit would_stop(logic [7:0] c);
    int       d;
    int       n;
    in_word_t w;
    d = nest_depth[M_PLAN];
    nest_depth[M_TRY]  = d;
    cur_line[M_TRY]    = cur_line[M_PLAN];
    scan_st[M_TRY]     = scan_st[M_PLAN];
    after_slash[M_TRY] = after_slash[M_PLAN];
    halted[M_TRY]      = halted[M_PLAN];
    if (d > 0) begin
      brk_kind[M_TRY][d-1] = brk_kind[M_PLAN][d-1];
      brk_line[M_TRY][d-1] = brk_line[M_PLAN][d-1];
    end
    w.cmd       = CMD_CHAR;
    w.char_code = c;
    n = nest_step(M_TRY, w);
    return (n > 0) && (step_out[M_TRY][n-1].kind == KIND_VERDICT);
  endfunction

  task automatic feed_word(in_word_t w);
    void'(nest_step(M_PLAN, w));
    pending_words.push_back(w);
  endtask

  task automatic feed_char(logic [7:0] c);
    in_word_t w;
    w.cmd       = CMD_CHAR;
    w.char_code = c;
    feed_word(w);
  endtask

  function automatic logic [7:0] pick_char(int goal);
    int roll;
    int d;
    roll = $urandom_range(0, 99);
    d    = nest_depth[M_PLAN];
    if (roll < 5) return 8'($urandom_range(0, 255));
    if (roll < 50) begin
      if (d > 0 && (d >= goal || $urandom_range(0, 3) == 0))
        return (brk_kind[M_PLAN][d-1] == STK_CURLY) ? CH_RBRACE : CH_RPAREN;
      return $urandom_range(0, 1) ? CH_LBRACE : CH_LPAREN;
    end
    if (roll < 70) return ($urandom_range(0, 4) == 0) ? CH_SPACE : 8'($urandom_range(97, 122));
    if (roll < 78) return CH_NEWLINE;
    if (roll < 84) return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    if (roll < 92) return CH_SLASH;
    if (roll < 95) return CH_STAR;
    return $urandom_range(0, 1) ? CH_RPAREN : CH_RBRACE;
  endfunction

  task automatic gen_text(int count);
    int         goal;
    int         tries;
    logic [7:0] c;
    goal = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0)
        goal = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 8);
      tries = 0;
      do begin
        c = pick_char(goal);
        tries++;
      end while (tries < 8 && would_stop(c));
      if (would_stop(c)) c = CH_LETTER;
      feed_char(c);
    end
  endtask

  task automatic close_all();
    feed_char(CH_NEWLINE);
    while (nest_depth[M_PLAN] > 0)
      feed_char((brk_kind[M_PLAN][nest_depth[M_PLAN]-1] == STK_CURLY) ? CH_RBRACE : CH_RPAREN);
  endtask

  task automatic note_mismatch(string what, int got, int want);
    mismatches++;
    $display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // sender: bursts with gaps, one drain pause
  always @(posedge clk) begin : sender
    int n;
    if (!rst_n) begin
      push       <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (push && !full) begin
        n = nest_step(M_CHECK, in_word);
        for (int k = 0; k < n; k++) expected_words.push_back(step_out[M_CHECK][k]);
        words_sent++;
      end
      if (!push || !full) begin
        if (pending_words.size() == 0 ||
            (words_sent == DRAIN_AT && expected_words.size() != 0)) begin
          push <= 1'b0;
        end else if (gap_left != 0) begin
          push     <= 1'b0;
          gap_left <= gap_left - 1;
        end else begin
          push    <= 1'b1;
          in_word <= pending_words.pop_front();
          if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
              burst_left <= $urandom_range(100, 400);
              gap_left   <= 0;
            end else begin
              burst_left <= $urandom_range(0, 20);
              gap_left   <= $urandom_range(1, 8);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: checks each popped word, stalls on a rotating pattern
  always @(posedge clk) begin : receiver
    out_word_t want;
    if (!rst_n) begin
      pop         <= 1'b0;
      stall_pat   <= '1;
      stall_phase <= '0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          note_mismatch("word with nothing expected", int'(out_word), 0);
        end else begin
          want = expected_words.pop_front();
          if (out_word.kind != want.kind)
            note_mismatch("kind", int'(out_word.kind), int'(want.kind));
          if (out_word.bracket != want.bracket)
            note_mismatch("bracket", int'(out_word.bracket), int'(want.bracket));
          if (out_word.verdict != want.verdict)
            note_mismatch("verdict", int'(out_word.verdict), int'(want.verdict));
          if (out_word.line_number != want.line_number)
            note_mismatch("line_number", int'(out_word.line_number),
                          int'(want.line_number));
          if (out_word.last != want.last)
            note_mismatch("last", int'(out_word.last), int'(want.last));
        end
      end
      pop         <= stall_pat[stall_phase];
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase == 5'd31) begin
        if ($urandom_range(0, 3) == 0) stall_pat <= '1;
        else if ($urandom_range(0, 2) == 0) stall_pat <= $urandom & $urandom;
        else stall_pat <= $urandom;
      end
    end
  end

  initial begin
    finale_t  finale;
    in_word_t w;
    for (int m = M_CHECK; m <= M_PLAN; m++) begin
      nest_depth[m]  = 0;
      cur_line[m]    = LINE_BITS'(1);
      scan_st[m]     = MODE_NORMAL;
      after_slash[m] = 1'b0;
      halted[m]      = 1'b0;
    end

    // nesting, quotes, comments inside quotes, unclosed quote, raw extremes
    feed_char(CH_LBRACE);  feed_char(CH_LPAREN); feed_char(CH_RPAREN); feed_char(CH_RBRACE);
    feed_char(CH_NEWLINE);
    feed_char(CH_SQUOTE);  feed_char(CH_LPAREN); feed_char(CH_SLASH);  feed_char(CH_SLASH);
    feed_char(CH_RBRACE);  feed_char(CH_NEWLINE);
    feed_char(CH_DQUOTE);  feed_char(CH_LBRACE); feed_char(CH_NEWLINE);
    feed_char(CH_SLASH);   feed_char(CH_STAR);   feed_char(CH_RPAREN); feed_char(CH_NEWLINE);
    feed_char(8'd0);       feed_char(8'd255);
    feed_char(CH_SLASH);   feed_char(CH_LPAREN); feed_char(CH_RPAREN); feed_char(CH_NEWLINE);

    finale = finale_t'($urandom_range(FIN_BALANCED, FIN_EMPTY_CLOSE));
    gen_text((finale == FIN_OVERFLOW) ? 100 : 1100);

    case (finale)
      FIN_BALANCED: close_all();
      FIN_OPEN: begin
        close_all();
        feed_char(CH_LBRACE);
        if ($urandom_range(0, 1)) feed_char(CH_LPAREN);
      end
      FIN_BAD_ROUND: begin
        close_all();
        feed_char(CH_LBRACE);
        feed_char(CH_RPAREN);
      end
      FIN_BAD_CURLY: begin
        close_all();
        feed_char(CH_LPAREN);
        feed_char(CH_RBRACE);
      end
      FIN_CURLY_IN_ROUND: begin
        feed_char(CH_NEWLINE);
        feed_char(CH_LPAREN);
        feed_char(CH_NEWLINE);
        feed_char(CH_LBRACE);
      end
      FIN_OVERFLOW: begin
        close_all();
        w.char_code = $urandom_range(0, 1) ? CH_LBRACE : CH_LPAREN;
        for (int i = 0; i < STACK_DEPTH + 4; i++) feed_char(w.char_code);
      end
      default: begin
        close_all();
        feed_char($urandom_range(0, 1) ? CH_RBRACE : CH_RPAREN);
      end
    endcase
    w.cmd       = CMD_END;
    w.char_code = 8'($urandom_range(0, 255));
    feed_word(w);

    // checker is stopped now; all of these must be ignored
    for (int i = 0; i < 16; i++) begin
      w.cmd       = 1'($urandom_range(0, 1));
      w.char_code = 8'($urandom_range(0, 255));
      feed_word(w);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || push) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
